### rtl/vqdm_pkg.sv
// ----------------------------------------------------------------------------
// vqdm_pkg
// Shared types and constants of the virtqueue descriptor manager.
// ----------------------------------------------------------------------------
package vqdm_pkg;

  localparam int MAX_QUEUE_DEPTH_DEF = 256;
  localparam logic [3:0] QSIZE_LOG2_RESET = 4'd8;
  localparam logic [15:0] NO_HEAD = 16'hFFFF;
  localparam int FLAG_NEXT_BIT = 0;
  localparam logic QSIZE_REG_IDX = 1'b0;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_SET   = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] len;
    logic [15:0] flags;
    logic [15:0] next;
  } desc_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        kick_request;
    logic [15:0] index;
    logic [8:0]  count;
    logic [63:0] buffer_address;
    logic [31:0] buffer_length;
    logic [15:0] desc_flags;
    logic [15:0] next_index;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] chain_head;
    logic [8:0]  free_count;
    logic [7:0]  avail_position;
    logic [15:0] avail_index_out;
    logic [8:0]  freed_count;
  } out_item_t;

endpackage

### rtl/vqdm_desc_ram.sv
// ----------------------------------------------------------------------------
// vqdm_desc_ram
// Descriptor table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vqdm_desc_ram
  import vqdm_pkg::*;
#(
  parameter int DEPTH = MAX_QUEUE_DEPTH_DEF,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  desc_t         wdata,
  input  logic [AW-1:0] raddr,
  output desc_t         rdata
);

  desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/virtqueue_descriptor_manager_core.sv
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_core
// Split virtqueue descriptor table with free list, alloc, set, free walk,
// kick and init sweep.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_ready  | in_item_t
//  out_     | output    | out_valid/out_ready| out_item_t
//  config   | input     | APB psel/penable   | queue_size_log2 at 0x0
//
//  Kick, set and rejected commands: S_IDLE, then S_DONE into the output register.
//  Alloc of n: S_ALLOC follows n links, one table read per link, then S_DONE.
//  Free walk: S_FREE_RD reads, then S_FREE_WR writes back each descriptor; then S_DONE.
//  Init: S_SWEEP writes all MAX_QUEUE_DEPTH entries, one table entry written per cycle, then S_DONE.
//  Reset starts the same sweep, with in_ready low until it ends.
//  A result waiting in the output register stalls only the next result.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_core
  import vqdm_pkg::*;
#(
  parameter int MAX_QUEUE_DEPTH = MAX_QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CL     = $clog2(MAX_QUEUE_DEPTH);
  localparam int LG_MAX = ((1 << CL) == MAX_QUEUE_DEPTH) ? CL : CL - 1;
  localparam int AW     = (CL > 0) ? CL : 1;
  localparam int QW     = LG_MAX + 1;
  localparam int CW     = 17;
  localparam int LG_RST = (LG_MAX < 8) ? LG_MAX : 8;
  localparam logic [QW-1:0] Q_RESET  = QW'(1) << LG_RST;
  localparam logic [AW-1:0] LAST_ENT = AW'(MAX_QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SWEEP   = 6'b000010,
    S_ALLOC   = 6'b000100,
    S_FREE_RD = 6'b001000,
    S_FREE_WR = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [3:0]      qlog2_r, qlog2_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [QW-1:0]   free_r, free_nxt;
  logic [15:0]     avail_r, avail_nxt;
  logic [QW-1:0]   sweep_q_r, sweep_q_nxt;
  logic [AW-1:0]   sweep_addr_r, sweep_addr_nxt;
  logic            sweep_reply_r, sweep_reply_nxt;
  logic [QW-1:0]   steps_r, steps_nxt;
  logic [8:0]      alloc_left_r, alloc_left_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic            res_status_r, res_status_nxt;
  logic [15:0]     res_head_r, res_head_nxt;
  logic [7:0]      res_apos_r, res_apos_nxt;
  logic [15:0]     res_aout_r, res_aout_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [3:0]      lg_eff, lg_new;
  logic [QW-1:0]   q, q_mask, q_new, q_mask_new;
  logic [AW-1:0]   mask_a;
  logic            idx_ok, nx_in_range, cfg_wr;
  logic [AW-1:0]   nx_alloc;
  logic [CW-1:0]   sw_inc;
  logic [15:0]     sw_next;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  desc_t           mem_wdata, mem_rdata;

  vqdm_desc_ram #(
    .DEPTH (MAX_QUEUE_DEPTH),
    .AW    (AW)
  ) u_desc_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign lg_eff     = (qlog2_r > 4'(LG_MAX)) ? 4'(LG_MAX) : qlog2_r;
  assign q          = QW'(1) << lg_eff;
  assign q_mask     = q - QW'(1);
  assign mask_a     = AW'(q_mask);
  assign lg_new     = (pwdata[3:0] > 4'(LG_MAX)) ? 4'(LG_MAX) : pwdata[3:0];
  assign q_new      = QW'(1) << lg_new;
  assign q_mask_new = q_new - QW'(1);

  assign idx_ok      = {1'b0, in_data.index} < CW'(q);
  assign nx_in_range = {1'b0, mem_rdata.next} < CW'(q);
  assign nx_alloc    = mem_rdata.next[AW-1:0] & mask_a;
  assign sw_inc      = CW'(sweep_addr_r) + CW'(1);
  assign sw_next     = (sw_inc < CW'(sweep_q_r)) ? 16'(sw_inc) : 16'd0;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == QSIZE_REG_IDX) ? {28'd0, qlog2_r} : 32'd0;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    qlog2_nxt       = qlog2_r;
    head_nxt        = head_r;
    free_nxt        = free_r;
    avail_nxt       = avail_r;
    sweep_q_nxt     = sweep_q_r;
    sweep_addr_nxt  = sweep_addr_r;
    sweep_reply_nxt = sweep_reply_r;
    steps_nxt       = steps_r;
    alloc_left_nxt  = alloc_left_r;
    cur_nxt         = cur_r;
    res_status_nxt  = res_status_r;
    res_head_nxt    = res_head_r;
    res_apos_nxt    = res_apos_r;
    res_aout_nxt    = res_aout_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    mem_we          = 1'b0;
    mem_waddr       = sweep_addr_r;
    mem_wdata       = '0;
    mem_raddr       = head_r & mask_a;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          steps_nxt      = '0;
          res_status_nxt = 1'b0;
          res_head_nxt   = 16'd0;
          res_apos_nxt   = 8'd0;
          res_aout_nxt   = 16'd0;
          if (in_data.kick_request) begin
            res_apos_nxt = 8'(avail_r & 16'(q_mask));
            avail_nxt    = avail_r + 16'd1;
            res_aout_nxt = avail_r + 16'd1;
            res_head_nxt = in_data.index;
            state_nxt    = S_DONE;
          end else begin
            case (cmd_t'(in_data.cmd))
              CMD_INIT: begin
                sweep_q_nxt     = q;
                head_nxt        = '0;
                free_nxt        = q;
                avail_nxt       = 16'd0;
                sweep_addr_nxt  = '0;
                sweep_reply_nxt = 1'b1;
                state_nxt       = S_SWEEP;
              end
              CMD_ALLOC: begin
                if ((in_data.count == 9'd0) || (CW'(in_data.count) > CW'(free_r))) begin
                  res_status_nxt = 1'b1;
                  res_head_nxt   = NO_HEAD;
                  state_nxt      = S_DONE;
                end else begin
                  res_head_nxt   = 16'(head_r & mask_a);
                  alloc_left_nxt = in_data.count;
                  free_nxt       = QW'(CW'(free_r) - CW'(in_data.count));
                  state_nxt      = S_ALLOC;
                end
              end
              CMD_SET: begin
                if (idx_ok) begin
                  mem_we          = 1'b1;
                  mem_waddr       = in_data.index[AW-1:0];
                  mem_wdata.addr  = in_data.buffer_address;
                  mem_wdata.len   = in_data.buffer_length;
                  mem_wdata.flags = in_data.desc_flags;
                  mem_wdata.next  = in_data.next_index;
                end else begin
                  res_status_nxt = 1'b1;
                end
                state_nxt = S_DONE;
              end
              CMD_FREE: begin
                if (idx_ok) begin
                  cur_nxt   = in_data.index[AW-1:0];
                  state_nxt = S_FREE_RD;
                end else begin
                  res_status_nxt = 1'b1;
                  state_nxt      = S_DONE;
                end
              end
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_SWEEP: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_addr_r;
        mem_wdata.next = sw_next;
        if (sweep_addr_r == LAST_ENT) begin
          state_nxt = sweep_reply_r ? S_DONE : S_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + AW'(1);
        end
      end
      S_ALLOC: begin
        head_nxt       = nx_alloc;
        mem_raddr      = nx_alloc;
        alloc_left_nxt = alloc_left_r - 9'd1;
        if (alloc_left_r == 9'd1) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE_RD: begin
        mem_raddr = cur_r;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = cur_r;
        mem_wdata.next = 16'(head_r);
        head_nxt       = cur_r;
        steps_nxt      = steps_r + QW'(1);
        if (free_r < q) begin
          free_nxt = free_r + QW'(1);
        end
        if (!mem_rdata.flags[FLAG_NEXT_BIT] || !nx_in_range ||
            (steps_r + QW'(1) == q)) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = mem_rdata.next[AW-1:0];
          state_nxt = S_FREE_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status          = res_status_r;
          out_data_nxt.chain_head      = res_head_r;
          out_data_nxt.free_count      = 9'(free_r);
          out_data_nxt.avail_position  = res_apos_r;
          out_data_nxt.avail_index_out = res_aout_r;
          out_data_nxt.freed_count     = 9'(steps_r);
          out_valid_nxt                = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr && (paddr[2] == QSIZE_REG_IDX)) begin
      qlog2_nxt = pwdata[3:0];
      if (free_nxt > q_new) begin
        free_nxt = q_new;
      end
      head_nxt = head_nxt & AW'(q_mask_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      qlog2_r       <= QSIZE_LOG2_RESET;
      head_r        <= '0;
      free_r        <= Q_RESET;
      avail_r       <= 16'd0;
      sweep_q_r     <= Q_RESET;
      sweep_addr_r  <= '0;
      sweep_reply_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      qlog2_r       <= qlog2_nxt;
      head_r        <= head_nxt;
      free_r        <= free_nxt;
      avail_r       <= avail_nxt;
      sweep_q_r     <= sweep_q_nxt;
      sweep_addr_r  <= sweep_addr_nxt;
      sweep_reply_r <= sweep_reply_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r      <= steps_nxt;
    alloc_left_r <= alloc_left_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_head_r   <= res_head_nxt;
    res_apos_r   <= res_apos_nxt;
    res_aout_r   <= res_aout_nxt;
    out_data_r   <= out_data_nxt;
  end

  // free count never exceeds the queue size
  a_free_le_q: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(free_r) <= CW'(q))
    else $error("free count above queue size");

  // free list head stays inside the queue
  a_head_in_q: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(head_r) < CW'(q))
    else $error("free list head out of range");

  // one command at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

endmodule
